FILE: rtl/core/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by every module of the block.
package bba_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int WPTR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W  = WPTR_W + BIT_W;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

   // Port widths fixed by the item format.
   localparam int CMD_W      = 2;
   localparam int REQ_IDX_W  = 8;
   localparam int GRANT_W    = 8;
   localparam int USED_CNT_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_MARK  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } ffs_result_type;

endpackage

FILE: rtl/core/bba_ffs.sv
// Find-first-set priority encoder over one map word (lowest bit wins).
// Depends on bba_pkg.
module bba_ffs (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   output bba_pkg::ffs_result_type       result
);
   import bba_pkg::*;

   always_comb begin
      result.found = 1'b0;
      result.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            result.found = 1'b1;
            result.pos   = BIT_W'(i);
         end
      end
   end

endmodule

FILE: rtl/core/bitmap_block_allocator.sv
// First-fit bitmap block allocator: top level with sequencer and map memory.
// Depends on bba_pkg and bba_ffs.
//
// Usage:
//   req channel (req_valid / req_stall) carries one command item: allocate
//   the lowest free block, free req_block_index, or mark req_block_index
//   used. Out-of-range indexes and the unused command code change nothing.
//   rsp channel (rsp_valid / rsp_stall) returns exactly one item per
//   request: granted index (allocate only), status (1 = map full on
//   allocate) and the used-block count after the request.
// Sequencing:
//   One item at a time; req_stall is high from acceptance until the result
//   is taken. The map is read one 32-bit word per cycle through a registered
//   read port and a single shared find-first-set encoder scans that word.
//   Allocate fetches word 0, then scans the words in order up to the first
//   one holding a free block (one to eight words; a full map scans all eight).
//   Free / mark fetch the addressed word, then modify it. Unused command or
//   out-of-range index: answered with no map access.
//   Once the result is taken the sequencer returns to idle.
// Reset:
//   Synchronous, active high. Per-word valid bits make the whole map read as
//   free at once and the tally goes to zero; no clearing pass is needed.
// Back-pressure:
//   While rsp_stall is high the result item holds steady and no new request
//   is accepted.
module bitmap_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bba_pkg::CMD_W-1:0]         req_command,
   input  logic [bba_pkg::REQ_IDX_W-1:0]     req_block_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bba_pkg::GRANT_W-1:0]       rsp_granted_index,
   output logic                              rsp_status,
   output logic [bba_pkg::USED_CNT_W-1:0]    rsp_used_count
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_MODIFY,
      ST_RESP
   } state_type;

   state_type state_ff;

   // Latched request; the word index goes straight to the read pointer.
   cmd_type              cmd_ff;
   logic [BIT_W-1:0]     cmd_idx_ff;

   // Map memory: one word per 32 blocks, valid bit per word so reset clears at once.
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_vld_ff;

   // Read port: address presented in scan_ptr_ff, data registered.
   logic [WPTR_W-1:0]    scan_ptr_ff;
   logic [WPTR_W-1:0]    word_ptr_ff;    // address of the word now in rd_word_ff
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_vld_ff;

   logic [CNT_W-1:0]     tally_ff;

   logic [GRANT_W-1:0]    rsp_granted_index_ff;
   logic                  rsp_status_ff;
   logic [USED_CNT_W-1:0] rsp_used_count_ff;
   logic                  rsp_valid_ff;

   // Write port and next-state helpers.
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] cur_word;
   logic [CNT_W-1:0]     tally_in;
   ffs_result_type       ffs_res;
   logic [31:0]          hit_blk;
   logic                 hit_ok;
   logic                 last_word;
   logic [BIT_W-1:0]     bit_sel;
   logic                 bit_was;
   logic                 bit_set;
   logic                 req_in_range;
   logic                 req_take;

   assign req_take     = req_valid && !req_stall;
   assign req_in_range = 32'(req_block_index) < NUM_BLOCKS;
   assign req_stall    = (state_ff != ST_IDLE);

   assign cur_word = rd_vld_ff ? rd_word_ff : '0;

   // Shared encoder: searches the free bits of the current word.
   bba_ffs u_ffs (
      .word   (~cur_word),
      .result (ffs_res)
   );

   assign hit_blk   = 32'({word_ptr_ff, ffs_res.pos});
   assign hit_ok    = ffs_res.found && (hit_blk < NUM_BLOCKS);
   assign last_word = (word_ptr_ff == WPTR_W'(MAP_WORDS - 1));
   assign bit_sel   = cmd_idx_ff;
   assign bit_was   = cur_word[bit_sel];
   assign bit_set   = (cmd_ff == CMD_MARK);

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = cur_word;
      tally_in  = tally_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (hit_ok) begin
               mem_we               = 1'b1;
               mem_wdata[ffs_res.pos] = 1'b1;
               tally_in             = tally_ff + CNT_W'(1);
            end
         end
         ST_MODIFY: begin
            // Redundant free / mark leaves word and tally alone.
            if (bit_set != bit_was) begin
               mem_we             = 1'b1;
               mem_wdata[bit_sel] = bit_set;
               tally_in           = bit_set ? tally_ff + CNT_W'(1) : tally_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Map memory and its registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[word_ptr_ff] <= mem_wdata;
      end
      rd_word_ff <= map_mem[scan_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            word_vld_ff[word_ptr_ff] <= 1'b1;
         end
         rd_vld_ff <= word_vld_ff[scan_ptr_ff];
      end
   end

   // Sequencer with registered result item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         tally_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
         scan_ptr_ff          <= '0;
         word_ptr_ff          <= '0;
         cmd_ff               <= CMD_ALLOC;
         cmd_idx_ff           <= '0;
         rsp_granted_index_ff <= '0;
         rsp_status_ff        <= 1'b0;
         rsp_used_count_ff    <= '0;
      end else begin
         word_ptr_ff <= scan_ptr_ff;
         tally_ff    <= tally_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cmd_ff               <= cmd_type'(req_command);
                  cmd_idx_ff           <= req_block_index[BIT_W-1:0];
                  rsp_granted_index_ff <= '0;
                  rsp_status_ff        <= 1'b0;
                  rsp_used_count_ff    <= USED_CNT_W'(tally_ff);
                  priority if (req_command == CMD_ALLOC) begin
                     scan_ptr_ff <= '0;
                     state_ff    <= ST_FETCH;
                  end else if ((req_command == CMD_FREE || req_command == CMD_MARK)
                               && req_in_range) begin
                     scan_ptr_ff <= WPTR_W'(32'(req_block_index) >> BIT_W);
                     state_ff    <= ST_FETCH;
                  end else begin
                     // Unused code or out-of-range index: no map access.
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end
               end
            end
            ST_FETCH: begin
               // Read of the first word is in flight.
               scan_ptr_ff <= scan_ptr_ff + WPTR_W'(1);
               state_ff    <= (cmd_ff == CMD_ALLOC) ? ST_SCAN : ST_MODIFY;
            end
            ST_SCAN: begin
               priority if (hit_ok) begin
                  rsp_granted_index_ff <= GRANT_W'(hit_blk);
                  rsp_used_count_ff    <= USED_CNT_W'(tally_in);
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= ST_RESP;
               end else if (ffs_res.found || last_word) begin
                  // Only padding bits free, or all words used: map full.
                  rsp_status_ff <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_RESP;
               end else begin
                  scan_ptr_ff <= scan_ptr_ff + WPTR_W'(1);
               end
            end
            ST_MODIFY: begin
               rsp_used_count_ff <= USED_CNT_W'(tally_in);
               rsp_valid_ff      <= 1'b1;
               state_ff          <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_index_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_used_count    = rsp_used_count_ff;

endmodule

FILE: rtl/core/bba_checker.sv
// Port-level checks for bitmap_block_allocator, attached by bind.
// Depends on bba_pkg.
module bba_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [bba_pkg::CMD_W-1:0]         req_command,
   input logic [bba_pkg::REQ_IDX_W-1:0]     req_block_index,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [bba_pkg::GRANT_W-1:0]       rsp_granted_index,
   input logic                              rsp_status,
   input logic [bba_pkg::USED_CNT_W-1:0]    rsp_used_count
);
   import bba_pkg::*;

   // A pending result item is not dropped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // No new request is taken while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while result pending");

   // Full map reports no grant.
   a_full_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_granted_index == '0)
      else $error("grant index set on full map");

   // Tally never exceeds the block count.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_used_count) <= NUM_BLOCKS)
      else $error("used count out of range");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

FILE: tb/tb_bitmap_block_allocator.sv
// Self-checking bench for bitmap_block_allocator: random and directed command items,
// a scoreboard fed by a first-fit bitmap predictor. Depends on bba_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   // Code the block decodes as "do nothing"; not part of the package enum.
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
   localparam logic             STATUS_OK   = 1'b0;
   localparam logic             STATUS_FULL = 1'b1;

   // Longest run of cycles with no item moving on either channel before we give up.
   // Worst case per item adds a full sender gap, a full-map scan in the block
   // and a full receiver stall, so this leaves a wide margin.
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      logic [CMD_W-1:0]     command;
      logic [REQ_IDX_W-1:0] block_index;
      int                   gap;     // idle cycles before the item is offered
      bit                   drain;   // hold until every result is back
      bit                   idle;    // receiver may stall on this stretch
   } block_req_type;

   typedef struct {
      logic [GRANT_W-1:0]    granted;
      logic                  status;
      logic [USED_CNT_W-1:0] used;
   } block_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = '0;
   logic [REQ_IDX_W-1:0]  req_block_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [GRANT_W-1:0]    rsp_granted_index;
   logic                  rsp_status;
   logic [USED_CNT_W-1:0] rsp_used_count;

   // Stimulus waiting to be offered, and results the predictor has promised.
   block_req_type block_reqs[$];
   block_rsp_type block_expect[$];

   // Predictor state: one bit per block, 1 = used, packed in 32-bit words.
   logic [WORD_BITS-1:0] usage_words [MAP_WORDS] = '{default: '0};
   int                   used_blocks = 0;

   // Handshake tallies, each written by one process only (nonblocking), so a
   // process reading both at an edge sees a consistent pre-edge picture.
   int  req_total = 0;
   int  rsp_total = 0;
   bit  rsp_idle_on = 1'b0;
   int  fail_count = 0;
   int  gap_count = 0;
   int  stall_count = 0;
   int  quiet_cycles = 0;

   bitmap_block_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_used_count    (rsp_used_count)
   );

   always #1 clock = ~clock;

   // Set or clear one block's bit, keeping the used tally in step. Redundant
   // updates (freeing a free block, marking a used one) leave both alone.
   function automatic void set_block(int blk, bit used);
      if (usage_words[blk / WORD_BITS][blk % WORD_BITS] != used) begin
         usage_words[blk / WORD_BITS][blk % WORD_BITS] = used;
         used_blocks += used ? 1 : -1;
      end
   endfunction

   // Apply one command to the predicted map and return the result it must produce.
   function automatic block_rsp_type apply_request(logic [CMD_W-1:0] cmd,
                                                   logic [REQ_IDX_W-1:0] idx);
      block_rsp_type r;
      int            blk;
      r.granted = '0;
      r.status  = STATUS_OK;
      case (cmd)
         CMD_ALLOC: begin
            // Walk downward so the last hit is the lowest free block.
            blk = NUM_BLOCKS;
            for (int w = MAP_WORDS - 1; w >= 0; w--)
               for (int b = WORD_BITS - 1; b >= 0; b--)
                  if (!usage_words[w][b] && (w * WORD_BITS + b) < NUM_BLOCKS)
                     blk = w * WORD_BITS + b;
            if (blk < NUM_BLOCKS) begin
               set_block(blk, 1'b1);
               r.granted = blk[GRANT_W-1:0];
            end else begin
               r.status = STATUS_FULL;    // map full: state untouched
            end
         end
         CMD_FREE: if (int'(idx) < NUM_BLOCKS) set_block(int'(idx), 1'b0);
         CMD_MARK: if (int'(idx) < NUM_BLOCKS) set_block(int'(idx), 1'b1);
         default: ;                       // unused code changes nothing
      endcase
      r.used = used_blocks[USED_CNT_W-1:0];
      return r;
   endfunction

   // Queue one command item; the sender gap is drawn here when idling is on.
   task automatic queue_req(logic [CMD_W-1:0] cmd, logic [REQ_IDX_W-1:0] idx,
                            bit idle, bit drain);
      block_req_type it;
      it.command     = cmd;
      it.block_index = idx;
      it.idle        = idle;
      it.drain       = drain;
      it.gap         = idle ? int'($urandom_range(0, 14)) : 0;
      block_reqs.push_back(it);
   endtask

   // Random command with the given percent weights for allocate, free and mark;
   // whatever is left over goes to the unused code.
   task automatic queue_random(int p_alloc, int p_free, int p_mark, bit idle, bit drain);
      int               roll;
      logic [CMD_W-1:0] cmd;
      roll = $urandom_range(0, 99);
      if (roll < p_alloc)                       cmd = CMD_ALLOC;
      else if (roll < p_alloc + p_free)         cmd = CMD_FREE;
      else if (roll < p_alloc + p_free + p_mark) cmd = CMD_MARK;
      else                                      cmd = CMD_UNUSED;
      queue_req(cmd, REQ_IDX_W'($urandom_range(0, 255)), idle, drain);
   endtask

   // ---------------------------------------------------------------------
   // Request driver. Holds an item steady until taken, then waits out the
   // next item's gap (and a drain hold if asked) before offering it.
   // Prediction happens here, at the edge the block takes the item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit            req_fire;
      bit            rsp_fire;
      int            in_flight;
      block_req_type nxt;
      req_fire = req_valid && !req_stall;
      rsp_fire = rsp_valid && !rsp_stall;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         if (req_fire) begin
            block_expect.push_back(apply_request(req_command, req_block_index));
            req_total <= req_total + 1;
         end
         // Results still owed once this edge has settled.
         in_flight = req_total - rsp_total + int'(req_fire) - int'(rsp_fire);
         if (!req_valid || req_fire) begin
            if (block_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (gap_count < block_reqs[0].gap) begin
               gap_count++;
               req_valid <= 1'b0;
            end else if (block_reqs[0].drain && in_flight != 0) begin
               req_valid <= 1'b0;
            end else begin
               nxt = block_reqs.pop_front();
               gap_count = 0;
               req_valid       <= 1'b1;
               req_command     <= nxt.command;
               req_block_index <= nxt.block_index;
               rsp_idle_on     <= nxt.idle;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and receiver. Every taken item is checked against the
   // oldest prediction; the stall for the following item is drawn on take.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      block_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_total <= rsp_total + 1;
            if (block_expect.size() == 0) begin
               if (fail_count < 10)
                  $display("tb: unexpected result granted=%0d status=%0d used=%0d",
                           rsp_granted_index, rsp_status, rsp_used_count);
               fail_count++;
            end else begin
               want = block_expect.pop_front();
               if (rsp_granted_index !== want.granted || rsp_status !== want.status ||
                   rsp_used_count !== want.used) begin
                  if (fail_count < 10)
                     $display("tb: mismatch %0d exp/got: grant %0d/%0d status %0d/%0d used %0d/%0d",
                              rsp_total, want.granted, rsp_granted_index,
                              want.status, rsp_status, want.used, rsp_used_count);
                  fail_count++;
               end
            end
            stall_count = rsp_idle_on ? int'($urandom_range(0, 14)) : 0;
         end else if (stall_count != 0 && rsp_valid) begin
            stall_count--;
         end
         rsp_stall <= (stall_count != 0);
      end
   end

   // Watchdog: a long stretch with no item moving either way means a hang.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus plan, all queued at time zero, then reset and end-of-run.
   // ---------------------------------------------------------------------
   initial begin
      // Directed: back to back, no idling. Covers first allocations, the
      // redundant mark and free, word boundaries, top block and unused code.
      queue_req(CMD_ALLOC,  8'hFF, 1'b0, 1'b0);   // empty map -> block 0
      queue_req(CMD_ALLOC,  8'h00, 1'b0, 1'b0);   // -> block 1
      queue_req(CMD_MARK,   8'hFF, 1'b0, 1'b0);   // top block
      queue_req(CMD_MARK,   8'hFF, 1'b0, 1'b0);   // already used
      queue_req(CMD_FREE,   8'h00, 1'b0, 1'b0);
      queue_req(CMD_ALLOC,  8'h55, 1'b0, 1'b0);   // reuses block 0
      queue_req(CMD_FREE,   8'h00, 1'b0, 1'b0);
      queue_req(CMD_FREE,   8'h00, 1'b0, 1'b0);   // already free
      queue_req(CMD_MARK,   8'h00, 1'b0, 1'b0);
      queue_req(CMD_MARK,   8'd31, 1'b0, 1'b0);   // last bit of word 0
      queue_req(CMD_MARK,   8'd32, 1'b0, 1'b0);   // first bit of word 1
      queue_req(CMD_ALLOC,  8'hAA, 1'b0, 1'b0);   // -> block 2
      queue_req(CMD_FREE,   8'd1,  1'b0, 1'b0);
      queue_req(CMD_ALLOC,  8'h00, 1'b0, 1'b0);   // -> block 1 again
      queue_req(CMD_UNUSED, 8'hAA, 1'b0, 1'b0);
      queue_req(CMD_UNUSED, 8'h55, 1'b0, 1'b0);
      queue_req(CMD_MARK,   8'd128, 1'b0, 1'b0);
      queue_req(CMD_FREE,   8'd128, 1'b0, 1'b0);
      queue_req(CMD_FREE,   8'hFF, 1'b0, 1'b0);
      queue_req(CMD_FREE,   8'd31, 1'b0, 1'b0);

      // Mixed traffic with idling on both sides; starts after a full drain.
      for (int i = 0; i < 120; i++)
         queue_random(45, 30, 18, 1'b1, i == 0);

      // Fill the map: enough allocations to reach full from any state,
      // first stretch without idling, then with it.
      for (int i = 0; i < 262; i++)
         queue_req(CMD_ALLOC, REQ_IDX_W'($urandom_range(0, 255)), i >= 130, i == 0);

      // Full map: allocations must report full, then churn it back down.
      for (int i = 0; i < 4; i++)
         queue_req(CMD_ALLOC, REQ_IDX_W'($urandom_range(0, 255)), 1'b1, i == 0);
      for (int i = 0; i < 60; i++)
         queue_random(35, 45, 12, $urandom_range(0, 1), 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (block_reqs.size() != 0 || req_valid) @(negedge clock);
      while (block_expect.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
